[src/tam_pkg.sv]
// Shared types and constants for the tremolo amplitude modulator.
package tam_pkg;

   // Default sizes handed to the top level parameters.
   localparam int TABLE_SIZE_DEF  = 1024;
   localparam int SAMPLE_BITS_DEF = 24;

   // Configuration register file.
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 24;
   localparam int PHASE_STEP_W = 24;
   localparam int DEPTH_W      = 7;
   localparam int GAIN_W       = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP    = 2'd0,
      CSR_DEPTH_PERCENT = 2'd1,
      CSR_GAIN_LINEAR   = 2'd2
   } csr_index_type;

   localparam logic [GAIN_W-1:0]  GAIN_RESET = 24'd1048576;   // 1.0 in Q4.20
   localparam logic [GAIN_W-1:0]  GAIN_MAX   = 24'd10485760;  // +20 dB
   localparam logic [DEPTH_W-1:0] DEPTH_MAX  = 7'd100;

   // LFO phase accumulator.
   localparam int PHASE_W = 32;

   // Decoupling queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Cosine table entries are Q1.15.
   localparam int COS_W = 16;

   // Datapath widths and constants of the back end.
   localparam int                NUM_W       = 23;  // (200-d)*2^15 + d*cos, at most 6553600
   localparam logic [7:0]        DEPTH_FULL  = 8'd200;
   localparam int                FACTOR_W    = 46;  // gain * num + rounding, below 2^46
   localparam logic [FACTOR_W-1:0] FACTOR_RND = 46'd3276800;
   localparam int                FACTOR_SHIFT = 16; // 6553600 = 100 * 2^16
   localparam int                QUOT_IN_W   = FACTOR_W - FACTOR_SHIFT;  // 30 bits
   localparam int                RECIP_W     = 31;
   localparam logic [RECIP_W-1:0] RECIP_100  = 31'd1374389535;  // ceil(2^37 / 100)
   localparam int                RECIP_SHIFT = 37;
   localparam int                QUOT_W      = QUOT_IN_W + RECIP_W;
   localparam int                K_W         = 24;  // gain times factor, Q4.20
   localparam int                OUT_SHIFT   = 20;

   // Cosine table build constants (elaboration only).
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam int          TAYLOR_TERMS = 12;
   localparam logic [63:0] TAYLOR_DEN [TAYLOR_TERMS] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
   };

endpackage

[src/tam_front.sv]
// Front end: accepts input beats, derives the cosine table index and advances the LFO phase.
module tam_front
   import tam_pkg::*;
#(
   parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int IDX_W      = $clog2(TABLE_SIZE)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [PHASE_STEP_W-1:0]      phase_step,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_in_sample,
   output logic                         q_valid,
   input  logic                         q_ready,
   output logic [SAMPLE_BITS+IDX_W-1:0] q_data
);

   localparam int SCALE_W = $clog2(TABLE_SIZE + 1);
   localparam int SCL_W   = PHASE_W + SCALE_W;

   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [SCL_W-1:0]   scaled;
   logic [IDX_W-1:0]   idx;
   logic               accept;

   assign accept = req_valid && q_ready;

   // The index is the integer part of phase * TABLE_SIZE / 2^32.
   assign scaled = SCL_W'(phase_ff) * SCL_W'(TABLE_SIZE);
   assign idx    = scaled[PHASE_W +: IDX_W];

   assign q_valid   = req_valid;
   assign req_ready = q_ready;
   assign q_data    = {req_in_sample, idx};

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         phase_in = phase_ff + PHASE_W'(phase_step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

[src/tam_queue.sv]
// Short flip-flop queue that decouples the front end from the back end.
module tam_queue
   import tam_pkg::*;
#(
   parameter int DATA_W = SAMPLE_BITS_DEF,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[src/tam_cos_rom.sv]
// Cosine table in Q1.15, built at elaboration, with a registered read port.
module tam_cos_rom
   import tam_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF,
   localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [IDX_W-1:0]        rd_idx,
   output logic signed [COS_W-1:0] rd_data
);

   localparam logic [63:0] QUAD_DEN = 64'(2 * TABLE_SIZE);
   localparam logic [63:0] TBL_M    = 64'(TABLE_SIZE);

   // cos(pi/2 * v / TABLE_SIZE) in Q30 by a truncating Taylor series.
   function automatic logic [63:0] quarter_cos_q30(input logic [63:0] v);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        mag;
      logic signed [63:0] sum;
      x   = (PI_Q30 * v) / QUAD_DEN;
      x2  = (x * x) >> 30;
      mag = ONE_Q30;
      sum = $signed(ONE_Q30);
      for (int n = 0; n < TAYLOR_TERMS; n++) begin
         mag = ((mag * x2) >> 30) / TAYLOR_DEN[n];
         if ((n % 2) == 0) begin
            sum = sum - $signed(mag);
         end else begin
            sum = sum + $signed(mag);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      return sum;
   endfunction

   function automatic logic [COS_W-1:0] quarter_cos_q15(input logic [63:0] v);
      logic [63:0] c;
      c = (quarter_cos_q30(v) + 64'd16384) >> 15;
      if (c > 64'd32767) begin
         c = 64'd32767;
      end
      return c[COS_W-1:0];
   endfunction

   function automatic logic [COS_W-1:0] rom_entry(input logic [63:0] i);
      logic [63:0] u;
      u = 64'd4 * i;
      if (u <= TBL_M) begin
         return quarter_cos_q15(u);
      end else if (u <= 64'd2 * TBL_M) begin
         return -quarter_cos_q15(64'd2 * TBL_M - u);
      end else if (u <= 64'd3 * TBL_M) begin
         return -quarter_cos_q15(u - 64'd2 * TBL_M);
      end
      return quarter_cos_q15(64'd4 * TBL_M - u);
   endfunction

   logic [COS_W-1:0] cos_tbl [TABLE_SIZE];

   for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_entry
      localparam logic [COS_W-1:0] ENTRY = rom_entry(64'(gi));
      assign cos_tbl[gi] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= $signed(cos_tbl[rd_idx]);
      end
   end

endmodule

[src/tam_back.sv]
// Back end: table read, modulation factor, gain scaling, rounding and saturation.
module tam_back
   import tam_pkg::*;
#(
   parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int IDX_W      = $clog2(TABLE_SIZE)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [DEPTH_W-1:0]            depth_percent,
   input  logic [GAIN_W-1:0]             gain_linear,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [SAMPLE_BITS+IDX_W-1:0]  in_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample
);

   localparam int PW   = SAMPLE_BITS + K_W + 1;
   localparam int SH_W = PW - OUT_SHIFT;

   // Whole pipeline moves together whenever the output register can take a beat.
   logic adv;

   logic signed [COS_W-1:0]       cos_q;
   logic [DEPTH_W-1:0]            d_clamp;
   logic [GAIN_W-1:0]             g_clamp;
   logic [7:0]                    d_inv;
   logic signed [NUM_W+1:0]       dc_prod;
   logic [NUM_W+1:0]              num_full;
   logic [K_W-1:0]                k_val;
   logic signed [PW-1:0]          rnd_sum;
   logic signed [SH_W-1:0]        shifted;
   logic [SH_W-SAMPLE_BITS:0]     hi_bits;
   logic signed [SAMPLE_BITS-1:0] sat_val;

   logic                          v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [SAMPLE_BITS-1:0] s1_ff, s2_ff, s3_ff, s4_ff;
   logic [NUM_W-1:0]              num2_ff;
   logic [FACTOR_W-1:0]           t3_ff;
   logic [QUOT_W-1:0]             q4_ff;
   logic signed [PW-1:0]          p5_ff;
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_out_sample_ff;

   logic [NUM_W-1:0]              num2_in;
   logic [FACTOR_W-1:0]           t3_in;
   logic [QUOT_W-1:0]             q4_in;
   logic signed [PW-1:0]          p5_in;

   assign adv      = !rsp_valid_ff || rsp_ready;
   assign in_ready = adv;

   tam_cos_rom #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_cos_rom (
      .clock  (clock),
      .rd_en  (adv),
      .rd_idx (in_data[IDX_W-1:0]),
      .rd_data(cos_q)
   );

   always_comb begin
      d_clamp = (depth_percent > DEPTH_MAX) ? DEPTH_MAX : depth_percent;
      g_clamp = (gain_linear > GAIN_MAX) ? GAIN_MAX : gain_linear;

      // Modulation factor scaled by 200 * 2^15; always positive.
      d_inv    = DEPTH_FULL - {1'b0, d_clamp};
      dc_prod  = $signed({{(NUM_W + 2 - DEPTH_W){1'b0}}, d_clamp}) * (NUM_W + 2)'(cos_q);
      num_full = (NUM_W + 2)'({d_inv, 15'd0}) + dc_prod;
      num2_in  = num_full[NUM_W-1:0];

      t3_in = FACTOR_W'(48'(g_clamp) * 48'(num2_ff)) + FACTOR_RND;

      // Divide by 100 through a reciprocal multiply.
      q4_in = QUOT_W'(t3_ff[FACTOR_W-1:FACTOR_SHIFT]) * QUOT_W'(RECIP_100);
      k_val = q4_ff[RECIP_SHIFT +: K_W];

      p5_in = PW'(s4_ff) * $signed({1'b0, k_val});

      // Round half up, then saturate to the sample range.
      rnd_sum = p5_ff + $signed(PW'(1) <<< (OUT_SHIFT - 1));
      shifted = rnd_sum[PW-1:OUT_SHIFT];
      hi_bits = shifted[SH_W-1:SAMPLE_BITS-1];
      if ((hi_bits == '0) || (hi_bits == '1)) begin
         sat_val = shifted[SAMPLE_BITS-1:0];
      end else if (shifted[SH_W-1]) begin
         sat_val = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= in_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff             <= in_data[IDX_W +: SAMPLE_BITS];
         s2_ff             <= s1_ff;
         num2_ff           <= num2_in;
         s3_ff             <= s2_ff;
         t3_ff             <= t3_in;
         s4_ff             <= s3_ff;
         q4_ff             <= q4_in;
         p5_ff             <= p5_in;
         rsp_out_sample_ff <= sat_val;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_out_sample_ff;

endmodule

[src/tremolo_amplitude_modulator.sv]
// Top level of the tremolo amplitude modulator: configuration registers and block wiring.
//
// Usage: each beat on the req_ channel carries one signed audio sample. The block
// returns one beat on the rsp_ channel per input beat, in order: the sample times
// gain_linear (Q4.20) times the tremolo factor 1 - d/2 + d/2 * cos(phase), with d the
// depth in percent over 100, rounded half up and saturated to the sample range.
// The LFO phase is a 32-bit accumulator; its top bits pick a cosine table entry and
// it advances by phase_step after every accepted beat, so the first sample after
// reset sees phase zero.
// Configuration beats on the csr_ channel write phase_step (index 0), depth_percent
// (index 1) and gain_linear (index 2); other indexes are ignored. csr_ready is always
// high, and the registers are meant to be written while no samples are in flight.
// Each sample passes through the queue, the back end stages and the output register.
// Throughput: one sample per cycle unless a result waits on rsp_ready, set by the back end
// that moves as a whole; the four-entry queue behind the front end absorbs short output
// stalls. Reset clears the phase, the queue and all valid flags and loads the register
// defaults (step 0, depth 0, gain 1.0). While a result waits with rsp_ready low it holds
// and the back end freezes; input beats keep landing in the queue until it is full.
module tremolo_amplitude_modulator
   import tam_pkg::*;
#(
   parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_in_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_sample,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int DATA_W = SAMPLE_BITS + IDX_W;

   // Configuration registers.
   logic [PHASE_STEP_W-1:0] phase_step_ff, phase_step_in;
   logic [DEPTH_W-1:0]      depth_percent_ff, depth_percent_in;
   logic [GAIN_W-1:0]       gain_linear_ff, gain_linear_in;

   // Front end to queue, queue to back end.
   logic              fq_valid, fq_ready;
   logic [DATA_W-1:0] fq_data;
   logic              qb_valid, qb_ready;
   logic [DATA_W-1:0] qb_data;

   assign csr_ready = 1'b1;

   // Register writes are decoded by index; an unknown index leaves everything alone.
   always_comb begin
      phase_step_in    = phase_step_ff;
      depth_percent_in = depth_percent_ff;
      gain_linear_in   = gain_linear_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PHASE_STEP:    phase_step_in    = csr_data[PHASE_STEP_W-1:0];
            CSR_DEPTH_PERCENT: depth_percent_in = csr_data[DEPTH_W-1:0];
            CSR_GAIN_LINEAR:   gain_linear_in   = csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff    <= '0;
         depth_percent_ff <= '0;
         gain_linear_ff   <= GAIN_RESET;
      end else begin
         phase_step_ff    <= phase_step_in;
         depth_percent_ff <= depth_percent_in;
         gain_linear_ff   <= gain_linear_in;
      end
   end

   // The front end stamps each sample with its table index and steps the LFO.
   tam_front #(
      .TABLE_SIZE (TABLE_SIZE),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .phase_step   (phase_step_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_sample(req_in_sample),
      .q_valid      (fq_valid),
      .q_ready      (fq_ready),
      .q_data       (fq_data)
   );

   // The queue lets the front end keep taking samples while the back end is stalled.
   tam_queue #(
      .DATA_W(DATA_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fq_valid),
      .in_ready (fq_ready),
      .in_data  (fq_data),
      .out_valid(qb_valid),
      .out_ready(qb_ready),
      .out_data (qb_data)
   );

   // The back end does the arithmetic and owns the output register.
   tam_back #(
      .TABLE_SIZE (TABLE_SIZE),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .depth_percent (depth_percent_ff),
      .gain_linear   (gain_linear_ff),
      .in_valid      (qb_valid),
      .in_ready      (qb_ready),
      .in_data       (qb_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_sample(rsp_out_sample)
   );

endmodule

[src/tam_checker.sv]
// Port-level checker for the tremolo amplitude modulator and its bind statement.
module tam_checker
   import tam_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic signed [SAMPLE_BITS-1:0] req_in_sample,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_out_sample
);

   // Beats taken in but not yet answered.
   logic [7:0] pending_ff, pending_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_beat && !rsp_beat) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_beat && !req_beat) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // No result comes out right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Every result answers a sample that was taken in.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("result without an outstanding sample");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_sample))
      else $error("result changed while stalled");

   // A waiting input beat keeps its valid and its sample until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_in_sample))
      else $error("input sample changed or dropped while waiting");

endmodule

bind tremolo_amplitude_modulator tam_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_tam_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_in_sample (req_in_sample),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_sample(rsp_out_sample)
);
